// File: rtl/ordered_list_store_unit_macros.svh
// Assertion macros for the ordered list store.
// Expects clk and rst in scope at the point of use; no other dependencies.
`ifndef ORDERED_LIST_STORE_UNIT_MACROS_SVH
`define ORDERED_LIST_STORE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OLS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered list store: same-cycle check failed");
`define OLS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered list store: next-cycle check failed");
`else
`define OLS_ASSERT_IMP(label, ante, cons)
`define OLS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/ols_pkg.sv
// Shared types and constants for the ordered list store.
// No dependencies.
package ols_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int LEN_W        = 5;

  typedef enum logic [1:0] {
    REQ_APPEND,
    REQ_PREPEND,
    REQ_DELETE,
    REQ_SEARCH
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_TAIL_LINK,
    ST_WALK,
    ST_RELEASE,
    ST_DONE
  } state_t;

endpackage

// File: rtl/ordered_list_store_unit.sv
// Ordered list store: bounded singly linked list of signed 32-bit values.
// Depends on ols_pkg and ordered_list_store_unit_macros.svh.
//
// Usage
// - Request channel (in_valid/in_ready, req_type, value): one beat is one
//   request: append at tail, insert at head, delete first match, search.
// - Result channel (out_valid/out_ready, hit, refused, list_length): exactly
//   one beat per request, in request order.
// - Nodes live in two single-port-write, registered-read memories (values and
//   links). Freed nodes are chained into a free list through the link memory;
//   never-used nodes are handed out by a fill counter, so no clearing pass.
// - Path from accept to result valid: insert at head goes through ALLOC and
//   DONE; append adds TAIL_LINK to patch the old tail link when the list is
//   not empty; a full-list insert goes straight to DONE. Delete/search walk
//   the list in WALK, then RELEASE for a removal; the walk is set by one
//   link-memory read per node, each read address taken from the last read.
// - One request is in work at a time; a new request is accepted as soon as
//   the previous one has reached the output register.
// - Reset (synchronous, rst high): list empty, free list empty, fill count 0,
//   output register empty. Memory contents are left as they are.
// - Receiver stall: the result holds in the output register; the next request
//   is still accepted and worked, then waits in its done state until the
//   output register frees up.
`include "ordered_list_store_unit_macros.svh"

module ordered_list_store_unit #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         req_type,
  input  logic signed [ols_pkg::VALUE_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic                               refused,
  output logic [ols_pkg::LEN_W-1:0]          list_length
);

  localparam int AW = $clog2(CAPACITY);          // memory address bits
  localparam int IW = $clog2(CAPACITY + 1);      // node index incl. null
  localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

  // node memories
  logic [ols_pkg::VALUE_W-1:0] value_mem [CAPACITY];
  logic [IW-1:0]               link_mem  [CAPACITY];

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [ols_pkg::VALUE_W-1:0] rd_value;
  logic [IW-1:0]               rd_link;

  logic                        wr_link_en;
  logic                        wr_value_en;
  logic [AW-1:0]               wr_addr;
  logic [IW-1:0]               wr_link;

  // control and list state
  ols_pkg::state_t state, state_next;
  ols_pkg::req_t   req, req_next;
  logic [ols_pkg::VALUE_W-1:0] val, val_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [IW-1:0] free_head, free_head_next;
  logic [IW-1:0] fill, fill_next;
  logic [IW-1:0] count, count_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  logic          res_hit, res_hit_next;
  logic          res_refused, res_refused_next;
  logic          out_load;

  logic [IW-1:0] nxt;
  logic [IW-1:0] slot;
  logic          match;
  ols_pkg::req_t in_req;

  assign in_req   = ols_pkg::req_t'(req_type);
  assign in_ready = (state == ols_pkg::ST_IDLE);
  assign nxt      = (rd_link >= NULL_IDX) ? NULL_IDX : rd_link;
  assign match    = (rd_value == val);
  assign slot     = (free_head != NULL_IDX) ? free_head : fill;

  always_comb begin
    state_next       = state;
    req_next         = req;
    val_next         = val;
    head_next        = head;
    tail_next        = tail;
    free_head_next   = free_head;
    fill_next        = fill;
    count_next       = count;
    cur_next         = cur;
    prev_next        = prev;
    res_hit_next     = res_hit;
    res_refused_next = res_refused;
    rd_en            = 1'b0;
    rd_addr          = head[AW-1:0];
    wr_link_en       = 1'b0;
    wr_value_en      = 1'b0;
    wr_addr          = cur[AW-1:0];
    wr_link          = NULL_IDX;
    out_load         = 1'b0;

    case (state)
      ols_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_next         = in_req;
          val_next         = value;
          res_hit_next     = 1'b0;
          res_refused_next = 1'b0;
          if (in_req == ols_pkg::REQ_APPEND || in_req == ols_pkg::REQ_PREPEND) begin
            if (count == NULL_IDX) begin
              res_refused_next = 1'b1;
              state_next       = ols_pkg::ST_DONE;
            end else begin
              // fetch the link of the free-list head, popped next cycle
              rd_en      = (free_head != NULL_IDX);
              rd_addr    = free_head[AW-1:0];
              state_next = ols_pkg::ST_ALLOC;
            end
          end else if (head == NULL_IDX) begin
            state_next = ols_pkg::ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = head[AW-1:0];
            cur_next   = head;
            prev_next  = NULL_IDX;
            state_next = ols_pkg::ST_WALK;
          end
        end
      end

      ols_pkg::ST_ALLOC: begin
        if (free_head != NULL_IDX) begin
          free_head_next = nxt;
        end else begin
          fill_next = fill + 1'b1;
        end
        wr_value_en = 1'b1;
        wr_link_en  = 1'b1;
        wr_addr     = slot[AW-1:0];
        count_next  = count + 1'b1;
        if (req == ols_pkg::REQ_PREPEND) begin
          wr_link    = head;
          head_next  = slot;
          if (head == NULL_IDX) begin
            tail_next = slot;
          end
          state_next = ols_pkg::ST_DONE;
        end else if (head == NULL_IDX) begin
          wr_link    = NULL_IDX;
          head_next  = slot;
          tail_next  = slot;
          state_next = ols_pkg::ST_DONE;
        end else begin
          wr_link    = NULL_IDX;
          cur_next   = slot;
          state_next = ols_pkg::ST_TAIL_LINK;
        end
      end

      ols_pkg::ST_TAIL_LINK: begin
        wr_link_en = 1'b1;
        wr_addr    = tail[AW-1:0];
        wr_link    = cur;
        tail_next  = cur;
        state_next = ols_pkg::ST_DONE;
      end

      ols_pkg::ST_WALK: begin
        // rd_value/rd_link hold node cur
        if (match) begin
          res_hit_next = 1'b1;
          if (req == ols_pkg::REQ_DELETE) begin
            if (prev == NULL_IDX) begin
              head_next = nxt;
            end else begin
              wr_link_en = 1'b1;
              wr_addr    = prev[AW-1:0];
              wr_link    = nxt;
            end
            if (cur == tail) begin
              tail_next = prev;
            end
            state_next = ols_pkg::ST_RELEASE;
          end else begin
            state_next = ols_pkg::ST_DONE;
          end
        end else if (nxt == NULL_IDX) begin
          state_next = ols_pkg::ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = nxt[AW-1:0];
          prev_next = cur;
          cur_next  = nxt;
        end
      end

      ols_pkg::ST_RELEASE: begin
        // push the removed node onto the free list
        wr_link_en     = 1'b1;
        wr_addr        = cur[AW-1:0];
        wr_link        = free_head;
        free_head_next = cur;
        count_next     = count - 1'b1;
        state_next     = ols_pkg::ST_DONE;
      end

      ols_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ols_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ols_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ols_pkg::ST_IDLE;
      head      <= NULL_IDX;
      free_head <= NULL_IDX;
      fill      <= '0;
      count     <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      fill      <= fill_next;
      count     <= count_next;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    req         <= req_next;
    val         <= val_next;
    tail        <= tail_next;
    cur         <= cur_next;
    prev        <= prev_next;
    res_hit     <= res_hit_next;
    res_refused <= res_refused_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit         <= res_hit;
      refused     <= res_refused;
      list_length <= ols_pkg::LEN_W'(count);
    end
  end

  // node memories: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_value_en) begin
      value_mem[wr_addr] <= val;
    end
    if (wr_link_en) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      rd_value <= value_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

  `OLS_ASSERT_IMP(a_count_bound, 1'b1, count <= NULL_IDX)
  // when a node is removed, head moves on leaving WALK and the count drops only on leaving RELEASE
  `OLS_ASSERT_IMP(a_empty_head, state != ols_pkg::ST_RELEASE, (count == '0) == (head == NULL_IDX))
  `OLS_ASSERT_IMP(a_count_le_fill, 1'b1, count <= fill)
  `OLS_ASSERT_IMP(a_refuse_full, out_load && res_refused, count == NULL_IDX)
  `OLS_ASSERT_NXT(a_release_shrinks, state == ols_pkg::ST_RELEASE,
                  count == $past(count) - 1'b1)

endmodule
